>>> rtl/core/cstks_pkg.sv
`timescale 1ns / 1ps

package cstks_pkg;

  localparam int LENGTH_BITS_DEF = 12;
  localparam int CFG_W = 12;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 12'd255;

  localparam logic [1:0] K_BYTE = 2'd0;
  localparam logic [1:0] K_END  = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       quoted;
    logic       last;
  } result_t;

  // Results one accepted beat pushes into the output queue
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> rtl/core/cstks_scan.sv
`timescale 1ns / 1ps

module cstks_scan import cstks_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  in_t              item,
  input  logic [CFG_W-1:0] max_token_len,
  output push_t            push
);

  localparam int W = (LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W;
  localparam logic [W-1:0] CAP = W'((1 << LENGTH_BITS) - 1);

  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_SLASH    = 4'd1;
  localparam logic [3:0] M_LINE     = 4'd2;
  localparam logic [3:0] M_BLK      = 4'd3;
  localparam logic [3:0] M_BLKSTAR  = 4'd4;
  localparam logic [3:0] Q_OFFSET   = 4'd5;
  localparam logic [3:0] Q_IDLE     = 4'd5;
  localparam logic [3:0] Q_SLASH    = 4'd6;
  localparam logic [3:0] Q_BLKSTAR  = 4'd9;
  localparam logic [3:0] M_TOKEN    = 4'd10;
  localparam logic [3:0] M_QTOKEN   = 4'd11;
  localparam logic [3:0] M_DISCARD  = 4'd12;
  localparam logic [3:0] M_QDISCARD = 4'd13;

  typedef struct packed {
    logic                   ok;
    result_t                res;
    logic [3:0]             mode;
    logic [LENGTH_BITS-1:0] len;
  } step_t;

  logic [3:0]             mode;
  logic [3:0]             mode_next;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] len_next;
  logic [W-1:0]           limit;
  push_t                  push_c;

  function automatic logic is_ws(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic result_t mk(input logic [1:0] k, input logic [7:0] b, input logic q);
    result_t r;
    r.kind     = k;
    r.out_byte = b;
    r.quoted   = q;
    r.last     = 1'b0;
    return r;
  endfunction

  // Append one byte to the token, or flag overflow and start discarding
  function automatic step_t put_byte(input logic [7:0] b, input logic q,
                                     input logic [LENGTH_BITS-1:0] l,
                                     input logic [W-1:0] lim);
    step_t s;
    if (W'(l) >= lim) begin
      s.ok   = 1'b0;
      s.res  = mk(K_ERR, 8'd0, q);
      s.mode = q ? M_QDISCARD : M_DISCARD;
      s.len  = '0;
    end else begin
      s.ok   = 1'b1;
      s.res  = mk(K_BYTE, b, q);
      s.mode = q ? M_QTOKEN : M_TOKEN;
      s.len  = l + 1'b1;
    end
    return s;
  endfunction

  // Byte inside a token: closer ends it, anything else is appended
  function automatic step_t token_byte(input logic [7:0] b, input logic q,
                                       input logic [LENGTH_BITS-1:0] l,
                                       input logic [W-1:0] lim);
    step_t s;
    if ((q && b == CH_QUOTE) || (!q && is_ws(b))) begin
      s.ok   = 1'b1;
      s.res  = mk(K_END, 8'd0, q);
      s.mode = M_IDLE;
      s.len  = '0;
    end else begin
      s = put_byte(b, q, l, lim);
    end
    return s;
  endfunction

  always_comb begin
    limit = (W'(max_token_len) < CAP) ? W'(max_token_len) : CAP;
  end

  always_comb begin
    logic [3:0] m;
    logic       q;
    logic [3:0] base;
    logic [3:0] sub;
    logic [7:0] b;
    step_t      p;
    step_t      t;
    m         = (mode > M_QDISCARD) ? M_IDLE : mode;
    b         = item.src_byte;
    q         = (m >= Q_OFFSET) && (m < M_TOKEN);
    base      = q ? Q_OFFSET : M_IDLE;
    sub       = q ? (m - Q_OFFSET) : m;
    p         = '0;
    t         = '0;
    mode_next = m;
    len_next  = len;
    push_c    = '0;
    if (item.end_of_source) begin
      mode_next = M_IDLE;
      len_next  = '0;
      if (m == M_SLASH || m == Q_SLASH) begin
        p         = put_byte(CH_SLASH, q, len, limit);
        push_c.r0 = p.res;
        push_c.n  = 2'd1;
        if (p.ok) begin
          push_c.r1 = mk(K_END, 8'd0, q);
          push_c.n  = 2'd2;
        end
      end else if ((m >= Q_IDLE && m <= Q_BLKSTAR) || m == M_QTOKEN) begin
        push_c.r0 = mk(K_END, 8'd0, 1'b1);
        push_c.n  = 2'd1;
      end else if (m == M_TOKEN) begin
        push_c.r0 = mk(K_END, 8'd0, 1'b0);
        push_c.n  = 2'd1;
      end
    end else if (m < M_TOKEN) begin
      case (sub)
        M_IDLE: begin
          if (is_ws(b)) begin
            mode_next = m;
          end else if (b == CH_SLASH) begin
            mode_next = base + M_SLASH;
          end else if (!q && b == CH_QUOTE) begin
            mode_next = Q_IDLE;
          end else begin
            t         = token_byte(b, q, len, limit);
            push_c.r0 = t.res;
            push_c.n  = 2'd1;
            mode_next = t.mode;
            len_next  = t.len;
          end
        end
        M_SLASH: begin
          if (b == CH_SLASH) begin
            mode_next = base + M_LINE;
          end else if (b == CH_STAR) begin
            mode_next = base + M_BLKSTAR;
          end else begin
            // held slash was not an opener: it leads the token
            p         = put_byte(CH_SLASH, q, len, limit);
            push_c.r0 = p.res;
            push_c.n  = 2'd1;
            mode_next = p.mode;
            len_next  = p.len;
            if (p.ok) begin
              t         = token_byte(b, q, p.len, limit);
              push_c.r1 = t.res;
              push_c.n  = 2'd2;
              mode_next = t.mode;
              len_next  = t.len;
            end
          end
        end
        M_LINE: begin
          if (b == CH_LF) mode_next = base + M_IDLE;
        end
        M_BLK: begin
          if (b == CH_STAR) mode_next = base + M_BLKSTAR;
        end
        default: begin
          if (b == CH_SLASH) mode_next = base + M_IDLE;
          else if (b != CH_STAR) mode_next = base + M_BLK;
        end
      endcase
    end else if (m == M_TOKEN || m == M_QTOKEN) begin
      t         = token_byte(b, m == M_QTOKEN, len, limit);
      push_c.r0 = t.res;
      push_c.n  = 2'd1;
      mode_next = t.mode;
      len_next  = t.len;
    end else if (m == M_DISCARD) begin
      if (is_ws(b)) begin
        mode_next = M_IDLE;
        len_next  = '0;
      end
    end else begin
      if (b == CH_QUOTE) begin
        mode_next = M_IDLE;
        len_next  = '0;
      end
    end
    if (push_c.n == 2'd1) push_c.r0.last = 1'b1;
    if (push_c.n == 2'd2) push_c.r1.last = 1'b1;
  end

  assign push = push_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      len  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      len  <= len_next;
    end
  end

endmodule

>>> rtl/core/cstks_queue.sv
`timescale 1ns / 1ps

module cstks_queue import cstks_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push_en,
  input  push_t   push,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  localparam int DEPTH = 4;

  result_t    slots [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [2:0] n_in;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // room for two results is needed before the next beat is taken
  assign full      = (count > 3'd2);
  assign n_in      = push_en ? {1'b0, push.n} : 3'd0;

  always_comb begin
    count_next = count + n_in - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_in[1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_in != 3'd0) slots[wr_ptr] <= push.r0;
    if (n_in == 3'd2) slots[wr_ptr + 1'b1] <= push.r1;
  end

endmodule

>>> rtl/core/comment_skipping_token_splitter.sv
`timescale 1ns / 1ps

// Splits a source byte stream into tokens, dropping whitespace and // and
// /* */ comments between them; a token opened by a double quote keeps its
// whitespace up to the closing quote. One source byte is taken per cycle
// while the queue has room; each yields zero, one or two results. Results
// leave one per cycle, unless the output stalls, through a four-entry
// output queue. Two results come only from the byte after a held slash,
// and the slash itself yields none. So while the output is never stalled,
// no source byte waits. Input is held off only while three or four
// results sit in the queue behind a stalled output. A result reaches the
// output in the cycle after its byte is accepted, if the queue is empty.
// The token length limit is written through the cfg port, always ready.
module comment_skipping_token_splitter import cstks_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] max_token_len;
  logic             accept;
  push_t            push;
  logic             full;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_token_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_token_len <= cfg_data;
    end
  end

  cstks_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (in_item),
    .max_token_len(max_token_len),
    .push         (push)
  );

  cstks_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_en  (accept),
    .push     (push),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

>>> rtl/core/cstks_checker.sv
`timescale 1ns / 1ps

module cstks_checker import cstks_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    out_valid,
  input logic    out_stall,
  input result_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.kind == K_BYTE || out_item.kind == K_END ||
                   out_item.kind == K_ERR))
    else $error("result kind out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != K_BYTE |-> out_item.out_byte == 8'd0)
    else $error("end or error beat carries a byte");

  a_mark_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != K_BYTE |-> out_item.last)
    else $error("end or error beat not marked last");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat offered right after reset");

endmodule

bind comment_skipping_token_splitter cstks_checker u_cstks_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
